@@ hdl/wavhp_pkg.sv @@
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

    // Four-character chunk tags, as they build up little-endian from the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // PCM format code in the fmt chunk
    localparam logic [31:0] FORMAT_PCM = 32'd1;

    // Bytes of the fmt chunk that are parsed; the rest are skipped
    localparam logic [31:0] FMT_STD_BYTES = 32'd16;

    // Result kinds
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_RIFF  = 3'd0;
    localparam logic [2:0] ERR_WAVE  = 3'd1;
    localparam logic [2:0] ERR_FMT   = 3'd2;
    localparam logic [2:0] ERR_PCM   = 3'd3;
    localparam logic [2:0] ERR_DEPTH = 3'd4;
    localparam logic [2:0] ERR_TRUNC = 3'd5;

    // Parser phase
    typedef enum logic [3:0] {
        PH_RIFF     = 4'd0,
        PH_SIZE     = 4'd1,
        PH_WAVE     = 4'd2,
        PH_FMT      = 4'd3,
        PH_FMTSIZE  = 4'd4,
        PH_FORMAT   = 4'd5,
        PH_CHAN     = 4'd6,
        PH_RATE     = 4'd7,
        PH_BYTERATE = 4'd8,
        PH_ALIGN    = 4'd9,
        PH_BITS     = 4'd10,
        PH_SKIP     = 4'd11,
        PH_TAG      = 4'd12,
        PH_CSIZE    = 4'd13,
        PH_DATA     = 4'd14,
        PH_IDLE     = 4'd15
    } t_phase;

    // One input byte with its file framing flags
    typedef struct packed {
        logic [7:0] byte_in;
        logic       file_start;
        logic       file_end;
    } t_wav_in;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sample_value;
        logic        last_sample;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [2:0]  error_code;
    } t_wav_out;

endpackage

@@ hdl/wav_header_parser_core.sv @@
// Byte-serial WAV (RIFF) header parser with sample assembly.
//
// Takes one byte of a WAV file per transfer, framed by file_start and file_end,
// and accepts a byte whenever the input side is ready: each byte updates the
// parser state in a single registered pass, and the result register loads at
// that same edge. Results (format report, audio sample or error) sit in one
// output register; the input side stays ready while that register is empty or
// is being taken in the same cycle, so the sustained rate is one byte per clock
// as long as the consumer takes results. Sample counting is done on the data
// chunk's remaining byte count, so no divider is needed. Errors are sticky: all
// bytes are dropped after an error or the last sample until the next file_start.
module wav_header_parser_core
    import wavhp_pkg::*;
#(
    parameter int MAX_SAMPLE_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_wav_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_wav_out o_out_item
);

    // State registers
    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_tag, n_tag;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;

    // Result register
    logic     r_out_valid;
    t_wav_out r_out_item;

    // Working values
    t_phase      base_phase;
    logic [1:0]  base_idx;
    logic [31:0] base_shift, base_bytes, base_tag, base_rate;
    logic [15:0] base_channels, base_depth;
    logic [12:0] depth_div;
    logic [2:0]  sbytes;
    logic [1:0]  g_last;
    logic [31:0] g_word;
    logic        g_done;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        n_emit;
    t_wav_out    n_item;
    logic        in_xfer;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Next state and result for the byte on the input
    always_comb begin
        // restart from clean state on the first byte of a file
        if (i_in_item.file_start) begin
            base_phase    = PH_RIFF;
            base_idx      = 2'd0;
            base_shift    = 32'd0;
            base_bytes    = 32'd0;
            base_tag      = 32'd0;
            base_channels = 16'd0;
            base_rate     = 32'd0;
            base_depth    = 16'd0;
        end else begin
            base_phase    = r_phase;
            base_idx      = r_idx;
            base_shift    = r_shift;
            base_bytes    = r_bytes;
            base_tag      = r_tag;
            base_channels = r_channels;
            base_rate     = r_rate;
            base_depth    = r_depth;
        end

        // bytes per sample, clamped to one..four
        depth_div = base_depth[15:3];
        if (depth_div == 13'd0) begin
            sbytes = 3'd1;
        end else if (depth_div > 13'd4) begin
            sbytes = 3'd4;
        end else begin
            sbytes = depth_div[2:0];
        end

        // index of the last byte of the field being gathered
        unique case (base_phase)
            PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS: g_last = 2'd1;
            PH_DATA:                               g_last = 2'(sbytes - 3'd1);
            default:                               g_last = 2'd3;
        endcase

        g_word = base_shift | (32'(i_in_item.byte_in) << {base_idx, 3'b000});
        g_done = base_idx >= g_last;

        n_phase    = base_phase;
        n_idx      = base_idx;
        n_shift    = base_shift;
        n_bytes    = base_bytes;
        n_tag      = base_tag;
        n_channels = base_channels;
        n_rate     = base_rate;
        n_depth    = base_depth;
        n_emit     = 1'b0;
        do_fail    = 1'b0;
        fail_code  = ERR_RIFF;
        n_item     = '0;

        // advance the field assembly in every gathering phase
        if (base_phase != PH_SKIP && base_phase != PH_IDLE) begin
            n_idx   = g_done ? 2'd0 : base_idx + 2'd1;
            n_shift = g_done ? 32'd0 : g_word;
        end

        unique case (base_phase)
            PH_RIFF: begin
                if (g_done) begin
                    if (g_word != TAG_RIFF) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_RIFF;
                    end else begin
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                if (g_done) n_phase = PH_WAVE;
            end
            PH_WAVE: begin
                if (g_done) begin
                    if (g_word != TAG_WAVE) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_WAVE;
                    end else begin
                        n_phase = PH_FMT;
                    end
                end
            end
            PH_FMT: begin
                if (g_done) begin
                    if (g_word != TAG_FMT) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_FMT;
                    end else begin
                        n_phase = PH_FMTSIZE;
                    end
                end
            end
            PH_FMTSIZE: begin
                if (g_done) begin
                    n_bytes = g_word;
                    n_phase = PH_FORMAT;
                end
            end
            PH_FORMAT: begin
                if (g_done) begin
                    if (g_word != FORMAT_PCM) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_PCM;
                    end else begin
                        n_phase = PH_CHAN;
                    end
                end
            end
            PH_CHAN: begin
                if (g_done) begin
                    n_channels = g_word[15:0];
                    n_phase    = PH_RATE;
                end
            end
            PH_RATE: begin
                if (g_done) begin
                    n_rate  = g_word;
                    n_phase = PH_BYTERATE;
                end
            end
            PH_BYTERATE: begin
                if (g_done) n_phase = PH_ALIGN;
            end
            PH_ALIGN: begin
                if (g_done) n_phase = PH_BITS;
            end
            PH_BITS: begin
                if (g_done) begin
                    n_depth = g_word[15:0];
                    if (!((n_depth == 16'd8 || n_depth == 16'd16 || n_depth == 16'd24 ||
                           n_depth == 16'd32) && n_depth <= 16'(MAX_SAMPLE_BITS))) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_DEPTH;
                    end else begin
                        n_emit      = 1'b1;
                        n_item.kind = KIND_FORMAT;
                        // skip any fmt bytes beyond the standard sixteen
                        if (base_bytes > FMT_STD_BYTES) begin
                            n_bytes = base_bytes - FMT_STD_BYTES;
                            n_phase = PH_SKIP;
                        end else begin
                            n_bytes = 32'd0;
                            n_phase = PH_TAG;
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (base_bytes <= 32'd1) begin
                    n_bytes = 32'd0;
                    n_phase = PH_TAG;
                end else begin
                    n_bytes = base_bytes - 32'd1;
                end
            end
            PH_TAG: begin
                if (g_done) begin
                    n_tag   = g_word;
                    n_phase = PH_CSIZE;
                end
            end
            PH_CSIZE: begin
                if (g_done) begin
                    n_bytes = g_word;
                    if (base_tag == TAG_DATA) begin
                        // fewer bytes than one sample means no samples at all
                        if (g_word < {29'd0, sbytes}) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_TRUNC;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_phase = (g_word != 32'd0) ? PH_SKIP : PH_TAG;
                    end
                end
            end
            PH_DATA: begin
                if (g_done) begin
                    n_emit              = 1'b1;
                    n_item.kind         = KIND_SAMPLE;
                    n_item.sample_value = g_word;
                    // last sample when less than two samples' worth remains
                    if (base_bytes < {28'd0, sbytes, 1'b0}) begin
                        n_item.last_sample = 1'b1;
                        n_bytes            = 32'd0;
                        n_phase            = PH_IDLE;
                    end else begin
                        n_bytes = base_bytes - {29'd0, sbytes};
                    end
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
        endcase

        // file ended with parsing unfinished
        if (i_in_item.file_end && !do_fail && n_phase != PH_IDLE) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNC;
        end

        // an error replaces any report or sample
        if (do_fail) begin
            n_phase             = PH_IDLE;
            n_emit              = 1'b1;
            n_item.kind         = KIND_ERROR;
            n_item.sample_value = 32'd0;
            n_item.last_sample  = 1'b0;
            n_item.error_code   = fail_code;
        end

        n_item.channel_count   = n_channels;
        n_item.sample_rate     = n_rate;
        n_item.bits_per_sample = n_depth;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_idx      <= 2'd0;
            r_shift    <= 32'd0;
            r_bytes    <= 32'd0;
            r_tag      <= 32'd0;
            r_channels <= 16'd0;
            r_rate     <= 32'd0;
            r_depth    <= 16'd0;
        end else if (in_xfer) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_shift    <= n_shift;
            r_bytes    <= n_bytes;
            r_tag      <= n_tag;
            r_channels <= n_channels;
            r_rate     <= n_rate;
            r_depth    <= n_depth;
        end
    end

    // Result register: load on an input transfer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_out_item <= n_item;
        end
    end

    // The final byte of a file always leaves the parser idle
    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_item.file_end |=> r_phase == PH_IDLE)
        else $error("parser not idle after final byte");

    // The last sample ends parsing of the file
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && n_emit && n_item.last_sample |=> r_phase == PH_IDLE)
        else $error("parser active after last sample");

    // Last-sample flag only on samples
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.last_sample |-> r_out_item.kind == KIND_SAMPLE)
        else $error("last flag on a non-sample result");

    // Error codes only on error results, and within range
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.kind != KIND_ERROR |-> r_out_item.error_code == ERR_RIFF)
        else $error("error code on a non-error result");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.kind == KIND_ERROR |-> r_out_item.error_code <= ERR_TRUNC)
        else $error("error code out of range");

endmodule
